[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Simulation builds get the checks;
// synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/fatp_pkg.sv]
package fatp_pkg;

  // Fixed field widths.
  localparam int OFS_W      = 16;
  localparam int THR_W      = 32;
  localparam int SYM_W      = 5;
  localparam int ALIGN_W    = 13;
  localparam int COPY_W     = 7;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Byte position width for the co-residence walk: a boundary byte plus up
  // to 127 alignment steps, kept in two's complement so that "minus one"
  // (an empty field at offset zero) never matches a line.
  localparam int POS_W     = 21;
  localparam int LINE_BITS = 6;

  // Request codes.
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ACCESS = 2'd1;
  localparam logic [1:0] REQ_MARKER = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_BELOW  = 2'd0;
  localparam logic [1:0] ST_INSIDE = 2'd1;
  localparam logic [1:0] ST_PAST   = 2'd2;
  localparam logic [1:0] ST_ACK    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_ALIGNMENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COPIES_PER_LINE = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [3:0]       entry_index;
    logic [3:0]       col_index;
    logic [OFS_W-1:0] field_start;
    logic [OFS_W-1:0] field_length;
    logic [OFS_W-1:0] access_offset;
    logic [THR_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [1:0]           match_status;
    logic [3:0]           matched_field;
    logic [OUT_CNT_W-1:0] row_hits;
    logic [OUT_CNT_W-1:0] transition_count;
    logic [OUT_CNT_W-1:0] sharing_count;
    logic [OUT_CNT_W-1:0] total_hits;
  } rsp_t;

  // Start of one co-residence walk.
  typedef struct packed {
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    logic [ALIGN_W-1:0] step;
    logic [COPY_W-1:0]  copies;
  } share_req_t;

  // Status of the co-residence unit.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [COPY_W-1:0] count;
  } share_rsp_t;

endpackage

[rtl/fatp_ram.sv]
module fatp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fatp_share.sv]
module fatp_share import fatp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  share_req_t req,
  output share_rsp_t rsp
);

  logic                run;
  logic                done;
  logic [POS_W-1:0]    lo;
  logic [POS_W-1:0]    hi;
  logic [ALIGN_W-1:0]  step;
  logic [COPY_W-1:0]   left;
  logic [COPY_W-1:0]   count;

  // Control: one copy is tested per cycle, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (go) begin
        run  <= 1'b1;
        done <= 1'b0;
      end else if (run && left == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      lo    <= req.lo;
      hi    <= req.hi;
      step  <= req.step;
      left  <= req.copies;
      count <= '0;
    end else if (run && left != '0) begin
      if (lo[POS_W-1:LINE_BITS] == hi[POS_W-1:LINE_BITS]) begin
        count <= count + COPY_W'(1);
      end
      lo   <= lo + POS_W'(step);
      hi   <= hi + POS_W'(step);
      left <= left - COPY_W'(1);
    end
  end

  assign rsp.busy  = run | done;
  assign rsp.done  = done;
  assign rsp.count = count;

endmodule

[rtl/field_access_transition_profiler.sv]
// Field access transition profiler.
//
// Items arrive on the req channel (req_valid, req_stall, req) and each one
// produces exactly one item on the rsp channel (rsp_valid, rsp_stall, rsp).
// An item is taken at a clock edge where valid is high and stall is low.
// One item at a time: a load or a marker passes through the execute and
// output steps, a counter read also waits for its memory reads, and the
// result register is loaded in the last step. An access reads and then
// compares each of the u = min(symbol_count, MAX_FIELDS) slots in use and
// finds the offset below the first field, past a field end or inside a
// field. A hit with a previous field updates the pair counters; on a
// thread change a co-residence walk first tests one object copy per cycle.
// Results wait in an output register; a new item is accepted while an older
// result is still held, and the sequencer only waits in its last step when
// the receiver keeps rsp_stall high with a result pending.
// The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// three configuration registers and is always ready.
// After reset (rst, synchronous) a clearing pass zeroes the hit and pair
// counter memories; req_stall stays high until it is over.
`include "assert_macros.svh"

module field_access_transition_profiler import fatp_pkg::*; #(
  parameter int MAX_FIELDS   = 16,
  parameter int COUNTER_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int PW  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS * MAX_FIELDS) : 1;
  localparam int CB  = COUNTER_BITS;
  localparam int CBX = COUNTER_BITS + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RDWAIT, S_SCAN_RD, S_SCAN_CMP,
    S_DECIDE, S_HIT, S_SHARE, S_PAIRWR, S_OUT
  } state_t;

  // Saturating add of a small increment.
  function automatic logic [CB-1:0] sat_add(logic [CB-1:0] a, logic [COPY_W-1:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + CBX'(b);
    return s[CB] ? '1 : s[CB-1:0];
  endfunction

  // Counters wider than the output read as all ones once above its range.
  function automatic logic [OUT_CNT_W-1:0] clip(logic [CB-1:0] v);
    return (64'(v) > 64'h0000_0000_FFFF_FFFF) ? '1 : OUT_CNT_W'(v);
  endfunction

  // Pair counter address for the transition from row r to column c.
  function automatic logic [PW-1:0] pair_addr(logic [IW-1:0] r, logic [IW-1:0] c);
    return PW'(r) * PW'(MAX_FIELDS) + PW'(c);
  endfunction

  state_t             state;
  req_t               item;
  logic [PW-1:0]      clr_addr;

  logic [SYM_W-1:0]   symbol_count;
  logic [ALIGN_W-1:0] type_alignment;
  logic [COPY_W-1:0]  copies_per_line;

  logic [IW-1:0]      prev_field;
  logic               prev_fv;
  logic [THR_W-1:0]   prev_thread;
  logic               prev_tv;
  logic [CB-1:0]      total;

  // Search state for an access.
  logic [SYM_W-1:0]   idx;
  logic [SYM_W-1:0]   cur;
  logic               found;
  logic [OFS_W-1:0]   cur_start;
  logic [OFS_W-1:0]   cur_len;

  logic [CB-1:0]      trans_old;
  logic [CB-1:0]      share_old;
  logic [COPY_W-1:0]  share_n;

  logic [1:0]           st;
  logic [OUT_CNT_W-1:0] res_hits;
  logic [OUT_CNT_W-1:0] res_trans;
  logic [OUT_CNT_W-1:0] res_share;
  logic [OUT_CNT_W-1:0] res_total;

  logic [SYM_W-1:0]   used;
  logic               clearing;
  logic               row_ok;
  logic               col_ok;

  // Memory ports.
  logic               tbl_we;
  logic [IW-1:0]      tbl_waddr;
  logic [IW-1:0]      tbl_raddr;
  logic [2*OFS_W-1:0] tbl_wdata;
  logic [2*OFS_W-1:0] tbl_rdata;
  logic               hit_we;
  logic [IW-1:0]      hit_waddr;
  logic [IW-1:0]      hit_raddr;
  logic [CB-1:0]      hit_wdata;
  logic [CB-1:0]      hit_rdata;
  logic               pair_we;
  logic [PW-1:0]      pair_waddr;
  logic [PW-1:0]      pair_raddr;
  logic [2*CB-1:0]    pair_wdata;
  logic [2*CB-1:0]    pair_rdata;

  logic [OFS_W-1:0]   prev_start;
  logic [OFS_W-1:0]   prev_len;
  logic               share_go;
  share_req_t         share_req;
  share_rsp_t         share_rsp;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign clearing  = (state == S_CLEAR);

  assign used   = (32'(symbol_count) > MAX_FIELDS) ? SYM_W'(MAX_FIELDS) : symbol_count;
  assign row_ok = (32'(item.entry_index) < MAX_FIELDS);
  assign col_ok = (32'(item.col_index) < MAX_FIELDS);

  assign prev_start = tbl_rdata[2*OFS_W-1:OFS_W];
  assign prev_len   = tbl_rdata[OFS_W-1:0];

  // Boundary bytes of the two fields: the last byte of the lower field and
  // the first byte of the upper one. The field read at S_HIT is the previous
  // field; the current field was captured during the search.
  always_comb begin
    if (cur_start > prev_start) begin
      share_req.lo = POS_W'(prev_start) + POS_W'(prev_len) - POS_W'(1);
      share_req.hi = POS_W'(cur_start);
    end else begin
      share_req.lo = POS_W'(cur_start) + POS_W'(cur_len) - POS_W'(1);
      share_req.hi = POS_W'(prev_start);
    end
    share_req.step   = type_alignment;
    share_req.copies = copies_per_line;
  end

  assign share_go = (state == S_HIT) && prev_fv && prev_tv &&
                    (prev_thread != item.thread_id);

  // Table memory: written by loads, read by the search and for the previous
  // field's bounds.
  assign tbl_we    = (state == S_EXEC) && (item.req_type == REQ_LOAD) && row_ok;
  assign tbl_waddr = IW'(item.entry_index);
  assign tbl_wdata = {item.field_start, item.field_length};
  assign tbl_raddr = (state == S_DECIDE) ? prev_field : IW'(idx);

  // Hit counter memory.
  assign hit_we    = clearing || (state == S_HIT);
  assign hit_waddr = clearing ? IW'(clr_addr) : IW'(cur);
  assign hit_wdata = clearing ? '0 : sat_add(hit_rdata, COPY_W'(1));
  assign hit_raddr = (state == S_EXEC) ? IW'(item.entry_index) : IW'(cur);

  // Pair memory holds the transition and sharing counters side by side.
  assign pair_we    = clearing || (state == S_PAIRWR);
  assign pair_waddr = clearing ? clr_addr : pair_addr(prev_field, IW'(cur));
  assign pair_wdata = clearing ? '0 :
                      {sat_add(trans_old, copies_per_line), sat_add(share_old, share_n)};
  assign pair_raddr = (state == S_EXEC) ?
                      pair_addr(IW'(item.entry_index), IW'(item.col_index)) :
                      pair_addr(prev_field, IW'(cur));

  fatp_ram #(.WIDTH(2 * OFS_W), .DEPTH(MAX_FIELDS)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  fatp_ram #(.WIDTH(COUNTER_BITS), .DEPTH(MAX_FIELDS)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (hit_waddr),
    .wdata (hit_wdata),
    .raddr (hit_raddr),
    .rdata (hit_rdata)
  );

  fatp_ram #(.WIDTH(2 * COUNTER_BITS), .DEPTH(MAX_FIELDS * MAX_FIELDS)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  fatp_share u_share (
    .clk (clk),
    .rst (rst),
    .go  (share_go),
    .req (share_req),
    .rsp (share_rsp)
  );

  // Sequencer: one item at a time, result handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      rsp_valid       <= 1'b0;
      symbol_count    <= '0;
      type_alignment  <= ALIGN_W'(8);
      copies_per_line <= COPY_W'(8);
      prev_field      <= '0;
      prev_fv         <= 1'b0;
      prev_thread     <= '0;
      prev_tv         <= 1'b0;
      total           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SYMBOL_COUNT:    symbol_count    <= cfg_data[SYM_W-1:0];
          CFG_TYPE_ALIGNMENT:  type_alignment  <= cfg_data[ALIGN_W-1:0];
          CFG_COPIES_PER_LINE: copies_per_line <= cfg_data[COPY_W-1:0];
          default: ;
        endcase
      end

      // A taken result is cleared unless the final step refills the register.
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PW'(1);
          if (clr_addr == PW'(MAX_FIELDS * MAX_FIELDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          st        <= ST_ACK;
          res_hits  <= '0;
          res_trans <= '0;
          res_share <= '0;
          res_total <= '0;
          unique case (item.req_type)
            REQ_LOAD: begin
              state <= S_OUT;
            end
            REQ_ACCESS: begin
              idx   <= '0;
              found <= 1'b0;
              cur   <= '0;
              state <= S_SCAN_RD;
            end
            REQ_MARKER: begin
              prev_fv <= 1'b0;
              prev_tv <= 1'b0;
              state   <= S_OUT;
            end
            REQ_READ: begin
              state <= S_RDWAIT;
            end
          endcase
        end

        S_RDWAIT: begin
          res_hits  <= row_ok ? clip(hit_rdata) : '0;
          res_trans <= (row_ok && col_ok) ? clip(pair_rdata[2*CB-1:CB]) : '0;
          res_share <= (row_ok && col_ok) ? clip(pair_rdata[CB-1:0]) : '0;
          res_total <= clip(total);
          state     <= S_OUT;
        end

        S_SCAN_RD: begin
          if (idx == used) begin
            state <= S_DECIDE;
          end else begin
            state <= S_SCAN_CMP;
          end
        end

        S_SCAN_CMP: begin
          // The highest slot whose start is not above the offset wins.
          if (tbl_rdata[2*OFS_W-1:OFS_W] <= item.access_offset) begin
            cur       <= idx;
            found     <= 1'b1;
            cur_start <= tbl_rdata[2*OFS_W-1:OFS_W];
            cur_len   <= tbl_rdata[OFS_W-1:0];
          end
          idx   <= idx + SYM_W'(1);
          state <= S_SCAN_RD;
        end

        S_DECIDE: begin
          if (!found) begin
            st          <= ST_BELOW;
            prev_thread <= item.thread_id;
            prev_tv     <= 1'b1;
            state       <= S_OUT;
          end else if ((OFS_W + 1)'(item.access_offset) >=
                       (OFS_W + 1)'(cur_start) + (OFS_W + 1)'(cur_len)) begin
            st          <= ST_PAST;
            prev_fv     <= 1'b0;
            total       <= sat_add(total, COPY_W'(1));
            prev_thread <= item.thread_id;
            prev_tv     <= 1'b1;
            state       <= S_OUT;
          end else begin
            // Reads of the hit, pair and previous-field entries are in flight.
            state <= S_HIT;
          end
        end

        S_HIT: begin
          trans_old <= pair_rdata[2*CB-1:CB];
          share_old <= pair_rdata[CB-1:0];
          if (!prev_fv) begin
            st          <= ST_INSIDE;
            prev_field  <= IW'(cur);
            prev_fv     <= 1'b1;
            total       <= sat_add(total, COPY_W'(1));
            prev_thread <= item.thread_id;
            prev_tv     <= 1'b1;
            state       <= S_OUT;
          end else if (share_go) begin
            state <= S_SHARE;
          end else begin
            share_n <= '0;
            state   <= S_PAIRWR;
          end
        end

        S_SHARE: begin
          if (share_rsp.done) begin
            share_n <= share_rsp.count;
            state   <= S_PAIRWR;
          end
        end

        S_PAIRWR: begin
          st          <= ST_INSIDE;
          prev_field  <= IW'(cur);
          prev_fv     <= 1'b1;
          total       <= sat_add(total, COPY_W'(1));
          prev_thread <= item.thread_id;
          prev_tv     <= 1'b1;
          state       <= S_OUT;
        end

        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.match_status     <= st;
            rsp.matched_field    <= (st == ST_INSIDE || st == ST_PAST) ? cur[3:0] : 4'd0;
            rsp.row_hits         <= res_hits;
            rsp.transition_count <= res_trans;
            rsp.sharing_count    <= res_share;
            rsp.total_hits       <= res_total;
            rsp_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The co-residence unit only runs while the sequencer waits for it.
  `ASSERT_IMPL(a_share_owned, clk, rst, share_rsp.busy, state == S_SHARE)
  // A remembered previous field always addresses a real table slot.
  `ASSERT_IMPL(a_prev_in_range, clk, rst, prev_fv, 32'(prev_field) < MAX_FIELDS)
  // A new result only appears after the sequencer's final step.
  `ASSERT_IMPL(a_rsp_from_out, clk, rst, $rose(rsp_valid), $past(state == S_OUT))
  // Once an item is taken the sequencer starts on it in the next cycle.
  `ASSERT_NEXT(a_accept_exec, clk, rst, req_valid && !req_stall, state == S_EXEC)

endmodule

[tb/sv/fatp_profile_model_pkg.sv]
`timescale 1ns / 1ps

package fatp_profile_model_pkg;
  import fatp_pkg::*;

  localparam int NFIELDS = 16;
  localparam logic [63:0] COUNT_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] LINE_MASK = ~64'd63;

  class fatp_profile_model;
    logic [SYM_W-1:0]   sym_count;
    logic [ALIGN_W-1:0] align_step;
    logic [COPY_W-1:0]  copies;

    logic [15:0] starts[NFIELDS];
    logic [15:0] lengths[NFIELDS];
    logic [63:0] hits[NFIELDS];
    logic [63:0] trans[NFIELDS * NFIELDS];
    logic [63:0] shares[NFIELDS * NFIELDS];
    logic [63:0] total;

    int          prev_field;
    bit          prev_field_ok;
    logic [31:0] prev_thread;
    bit          prev_thread_ok;

    rsp_t pending_rsp[$];
    int   errors;

    function new();
      sym_count = '0;
      align_step = 13'd8;
      copies = 7'd8;
      foreach (starts[i]) begin
        starts[i] = '0;
        lengths[i] = '0;
        hits[i] = '0;
      end
      foreach (trans[i]) begin
        trans[i] = '0;
        shares[i] = '0;
      end
      total = '0;
      prev_field = 0;
      prev_field_ok = 0;
      prev_thread = '0;
      prev_thread_ok = 0;
      errors = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SYMBOL_COUNT: sym_count = data[SYM_W-1:0];
        CFG_TYPE_ALIGNMENT: align_step = data[ALIGN_W-1:0];
        CFG_COPIES_PER_LINE: copies = data[COPY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (s < a || s > COUNT_MAX) return COUNT_MAX;
      return s;
    endfunction

    function logic [31:0] clip(logic [63:0] v);
      return (v > COUNT_MAX) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Number of object copies in which the boundary bytes of the two fields
    // fall into one cache line. The lower field's last byte may be "minus
    // one" for an empty field at offset zero; it wraps like the block does.
    function logic [63:0] shared_copies(int from, int to);
      logic [63:0] lo, hi, n;
      n = '0;
      if (starts[to] > starts[from]) begin
        lo = 64'(starts[from]) + 64'(lengths[from]) - 64'd1;
        hi = 64'(starts[to]);
      end else begin
        lo = 64'(starts[to]) + 64'(lengths[to]) - 64'd1;
        hi = 64'(starts[from]);
      end
      for (int k = 0; k < int'(copies); k++) begin
        if ((lo & LINE_MASK) == (hi & LINE_MASK)) n++;
        lo += 64'(align_step);
        hi += 64'(align_step);
      end
      return n;
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      int   used, cur, pair_idx, row, col;
      bit   found;
      want = '0;
      want.match_status = ST_ACK;
      row = int'(r.entry_index);
      col = int'(r.col_index);
      case (r.req_type)
        REQ_LOAD: begin
          starts[row] = r.field_start;
          lengths[row] = r.field_length;
        end
        REQ_ACCESS: begin
          used = (int'(sym_count) > NFIELDS) ? NFIELDS : int'(sym_count);
          found = 0;
          cur = 0;
          for (int i = 0; i < used; i++) begin
            if (starts[i] <= r.access_offset) begin
              cur = i;
              found = 1;
            end
          end
          if (!found) begin
            want.match_status = ST_BELOW;
          end else begin
            want.matched_field = 4'(cur);
            if (int'(r.access_offset) < int'(starts[cur]) + int'(lengths[cur])) begin
              want.match_status = ST_INSIDE;
              hits[cur] = sat_add(hits[cur], 64'd1);
              if (prev_field_ok) begin
                pair_idx = prev_field * NFIELDS + cur;
                trans[pair_idx] = sat_add(trans[pair_idx], 64'(copies));
                if (prev_thread_ok && prev_thread != r.thread_id)
                  shares[pair_idx] = sat_add(shares[pair_idx],
                                             shared_copies(prev_field, cur));
              end
              prev_field = cur;
              prev_field_ok = 1;
            end else begin
              want.match_status = ST_PAST;
              prev_field_ok = 0;
            end
            total = sat_add(total, 64'd1);
          end
          prev_thread = r.thread_id;
          prev_thread_ok = 1;
        end
        REQ_MARKER: begin
          prev_field_ok = 0;
          prev_thread_ok = 0;
        end
        default: begin
          want.row_hits = clip(hits[row]);
          want.transition_count = clip(trans[row * NFIELDS + col]);
          want.sharing_count = clip(shares[row * NFIELDS + col]);
          want.total_hits = clip(total);
        end
      endcase
      pending_rsp.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = pending_rsp.pop_front();
      compare_field("match_status", 32'(want.match_status), 32'(got.match_status));
      compare_field("matched_field", 32'(want.matched_field), 32'(got.matched_field));
      compare_field("row_hits", want.row_hits, got.row_hits);
      compare_field("transition_count", want.transition_count, got.transition_count);
      compare_field("sharing_count", want.sharing_count, got.sharing_count);
      compare_field("total_hits", want.total_hits, got.total_hits);
    endfunction
  endclass

endpackage

[tb/sv/tb_field_access_transition_profiler.sv]
`timescale 1ns / 1ps

module tb_field_access_transition_profiler;
  import fatp_pkg::*;
  import fatp_profile_model_pkg::*;

  // The slowest item is an access with a full table and a thread change:
  // the whole search plus the line walk.
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 35;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fatp_profile_model profile;

  // When steady is set, neither side idles: this gives stretches where the
  // block runs back to back.
  bit          steady;
  logic [31:0] thread_pool[3];
  int unsigned cycles;

  field_access_transition_profiler i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 19));
  endfunction

  // A request with every field random; callers then set the fields that
  // matter for the item. The unused fields stay random so that their bits
  // toggle as well.
  function automatic req_t rand_req();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic logic [31:0] pick_thread();
    if ($urandom_range(0, 99) < 85) return thread_pool[$urandom_range(0, 2)];
    return $urandom();
  endfunction

  // Most offsets land inside a field in use, some just past its end or a few
  // bytes before its start, and some anywhere.
  function automatic logic [15:0] pick_offset();
    int used, f, s, l, roll;
    used = (int'(profile.sym_count) > NFIELDS) ? NFIELDS : int'(profile.sym_count);
    roll = int'($urandom_range(0, 99));
    if (used == 0 || roll < 10) return 16'($urandom());
    f = int'($urandom_range(0, used - 1));
    s = int'(profile.starts[f]);
    l = int'(profile.lengths[f]);
    if (roll < 80 && l > 0) s = s + int'($urandom_range(0, l - 1));
    else if (roll < 90) s = s + l;
    else s = s - int'($urandom_range(0, 3));
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return 16'(s);
  endfunction

  // Present one item and hold it until the block takes it. Valid stays high
  // when the next item follows with no gap.
  task automatic send_item(req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    profile.note_request(r);
  endtask

  // Stop sending and wait until every result is back and the block is quiet.
  task automatic drain(int settle);
    req_valid <= 1'b0;
    @(posedge clk);
    while (profile.pending_rsp.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    profile.write_register(idx, data);
  endtask

  task automatic configure(int sym, int align, int copies);
    write_cfg(CFG_SYMBOL_COUNT, CFG_DATA_W'(sym));
    write_cfg(CFG_TYPE_ALIGNMENT, CFG_DATA_W'(align));
    write_cfg(CFG_COPIES_PER_LINE, CFG_DATA_W'(copies));
    cfg_valid <= 1'b0;
  endtask

  // Fill all sixteen slots. Kind 0 packs small fields close together so that
  // neighbors share cache lines, kind 1 spreads them over the whole offset
  // range, and kind 2 is a packed table with two slots swapped out of order.
  task automatic load_table(int kind);
    logic [15:0] st[NFIELDS];
    logic [15:0] ln[NFIELDS];
    logic [15:0] t;
    int          pos, a, b;
    req_t        r;
    pos = int'($urandom_range(0, 48));
    for (int i = 0; i < NFIELDS; i++) begin
      if (kind == 1) begin
        st[i] = 16'(i * 4096 + int'($urandom_range(0, 4095)));
        ln[i] = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 200));
      end else begin
        ln[i] = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
        st[i] = 16'(pos);
        pos = pos + int'(ln[i]) + int'($urandom_range(0, 6));
      end
    end
    if (kind == 2) begin
      a = int'($urandom_range(0, NFIELDS - 1));
      b = int'($urandom_range(0, NFIELDS - 1));
      t = st[a];
      st[a] = st[b];
      st[b] = t;
    end
    for (int i = 0; i < NFIELDS; i++) begin
      r = rand_req();
      r.req_type = REQ_LOAD;
      r.entry_index = 4'(i);
      r.field_start = st[i];
      r.field_length = ln[i];
      send_item(r);
    end
  endtask

  // One random item: mostly accesses into the loaded fields, with counter
  // reads, segment markers and the odd slot reload mixed in, plus some
  // accesses with fully random offset and thread as noise.
  task automatic random_item();
    req_t r;
    int   roll, used, idx;
    r = rand_req();
    roll = int'($urandom_range(0, 99));
    used = (int'(profile.sym_count) > NFIELDS) ? NFIELDS : int'(profile.sym_count);
    if (roll < 65) begin
      r.req_type = REQ_ACCESS;
      r.access_offset = pick_offset();
      r.thread_id = pick_thread();
    end else if (roll < 77) begin
      r.req_type = REQ_READ;
      if (used > 0 && $urandom_range(0, 1)) begin
        r.entry_index = 4'($urandom_range(0, used - 1));
        r.col_index = 4'($urandom_range(0, used - 1));
      end
    end else if (roll < 86) begin
      r.req_type = REQ_MARKER;
    end else if (roll < 93) begin
      // Reloading one slot near its old start can leave the table unsorted.
      r.req_type = REQ_LOAD;
      idx = int'(r.entry_index);
      if ($urandom_range(0, 3) != 0) begin
        r.field_start = profile.starts[idx] + 16'($urandom_range(0, 16)) - 16'd8;
        r.field_length = 16'($urandom_range(0, 24));
      end
    end else begin
      r.req_type = REQ_ACCESS;
    end
    send_item(r);
  endtask

  // Short directed run on a known table, with align and copies still at
  // their reset values: empty table, below the first field, transitions
  // with and without a thread change, past a field end, an empty field, the
  // top of the offset range, markers, and reads of corner entries.
  task automatic directed_part();
    req_t r;
    r = rand_req();
    r.req_type = REQ_ACCESS;
    r.access_offset = 16'd100;
    r.thread_id = 32'd0;
    send_item(r);
    for (int i = 0; i < NFIELDS; i++) begin
      r = rand_req();
      r.req_type = REQ_LOAD;
      r.entry_index = 4'(i);
      if (i < 13) begin
        r.field_start = 16'(16 + 10 * i);
        r.field_length = 16'd6;
      end else if (i == 13) begin
        r.field_start = 16'd200;
        r.field_length = 16'd0;
      end else if (i == 14) begin
        r.field_start = 16'd65000;
        r.field_length = 16'd100;
      end else begin
        r.field_start = 16'hFFFF;
        r.field_length = 16'hFFFF;
      end
      send_item(r);
    end
    drain(4);
    write_cfg(CFG_SYMBOL_COUNT, CFG_DATA_W'(NFIELDS));
    cfg_valid <= 1'b0;

    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd0;
    r.thread_id = 32'd0; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd16;
    r.thread_id = 32'd1; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd27;
    r.thread_id = 32'd1; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd18;
    r.thread_id = 32'd2; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd23;
    r.thread_id = 32'd2; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd37;
    r.thread_id = 32'd3; send_item(r);
    r = rand_req(); r.req_type = REQ_MARKER; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd46;
    r.thread_id = 32'd4; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'hFFFF;
    r.thread_id = 32'hFFFF_FFFF; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd300;
    r.thread_id = 32'd0; send_item(r);
    r = rand_req(); r.req_type = REQ_ACCESS; r.access_offset = 16'd65050;
    r.thread_id = 32'd0; send_item(r);
    r = rand_req(); r.req_type = REQ_READ; r.entry_index = 4'd0;
    r.col_index = 4'd1; send_item(r);
    r = rand_req(); r.req_type = REQ_READ; r.entry_index = 4'd1;
    r.col_index = 4'd0; send_item(r);
    r = rand_req(); r.req_type = REQ_READ; r.entry_index = 4'd3;
    r.col_index = 4'd15; send_item(r);
    r = rand_req(); r.req_type = REQ_READ; r.entry_index = 4'd15;
    r.col_index = 4'd15; send_item(r);
    r = rand_req(); r.req_type = REQ_READ; r.entry_index = 4'd0;
    r.col_index = 4'd0; send_item(r);
    drain(4);
  endtask

  // Result side: stall for a random number of cycles, then take the next
  // result and check it against the oldest expectation.
  initial begin
    int gap;
    rsp_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      profile.check_response(rsp);
    end
  end

  // Main sequence: reset, the directed part, then phases that each pick a
  // setting, load a fresh table and run a batch of random items.
  initial begin
    int sym, align, copies;
    profile = new();
    steady = 0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    foreach (thread_pool[i]) thread_pool[i] = $urandom();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_part();

    for (int p = 0; p < PHASES; p++) begin
      steady = (p % 3 == 1);
      foreach (thread_pool[i]) thread_pool[i] = $urandom();
      case (p)
        0: begin sym = 16; align = 1; copies = 64; end
        1: begin sym = 31; align = 8191; copies = 127; end
        2: begin sym = 0; align = 4096; copies = 1; end
        3: begin sym = 16; align = 0; copies = 0; end
        4: begin sym = 16; align = 64; copies = 1; end
        default: begin
          sym = int'($urandom_range(1, NFIELDS));
          align = 1 << $urandom_range(0, 7);
          if ($urandom_range(0, 3) == 0) align = int'($urandom_range(1, 4096));
          copies = (align >= 64) ? 1 : 64 / align;
        end
      endcase
      configure(sym, align, copies);
      // Index 3 names no register; the block must leave the others alone.
      if (p == 2) begin
        write_cfg(2'd3, CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
      end
      load_table(p % 3);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      drain(4);
    end

    drain(SETTLE_CYCLES);
    if (profile.errors == 0 && profile.pending_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
